// ===== rtl/wsd_pkg.sv =====
// ----------------------------------------------------------------------------
// wsd_pkg
// Shared types and constants for the WebSocket frame deframer.
// ----------------------------------------------------------------------------
package wsd_pkg;

   // result kinds on the response channel
   typedef enum logic [1:0] {
      KIND_DATA  = 2'd0,
      KIND_END   = 2'd1,
      KIND_CLOSE = 2'd2,
      KIND_ERROR = 2'd3
   } kind_type;

   // header byte 0 fields, and the mask bit of header byte 1
   localparam int unsigned FIN_BIT     = 7;
   localparam int unsigned MASK_BIT    = 7;
   localparam int unsigned CTL_OP_BIT  = 3;
   localparam logic [3:0]  OPCODE_CLOSE = 4'h8;

   // 7-bit length codes that select an extended length
   localparam logic [6:0]  LEN_CODE_16 = 7'd126;
   localparam logic [6:0]  LEN_CODE_64 = 7'd127;

   // total header bytes for each length form
   localparam logic [3:0]  HDR_LEN_SHORT = 4'd2;
   localparam logic [3:0]  HDR_LEN_16    = 4'd4;
   localparam logic [3:0]  HDR_LEN_64    = 4'd10;

   // one result word from the parser
   typedef struct packed {
      logic       valid;
      kind_type   kind;
      logic [7:0] data_byte;
      logic [3:0] msg_opcode;
      logic       msg_last;
   } result_type;

endpackage

// ===== rtl/websocket_frame_deframer.sv =====
// ----------------------------------------------------------------------------
// websocket_frame_deframer
// Server-to-client WebSocket frame parser with a byte-wide result stream.
// ----------------------------------------------------------------------------
// Accepts one received byte per clock and gives at most one result per byte:
// payload bytes of data frames tagged with the opcode of the message's first
// fragment (last byte of a final frame marked), an end marker for an empty
// final frame, a close event when a close frame completes, or a single error
// for a masked frame, after which all bytes are swallowed until reset.
// Sustained rate is one byte per cycle; a byte passes through the input
// register, then the result register, before its result is presented. Only the
// receiver slows the block: while it stalls a held result, the next byte
// waits in the input register and the input stalls once that is full. The
// longest path is the 64-bit payload countdown and its zero compare.
module websocket_frame_deframer import wsd_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_rx_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [1:0] rsp_out_kind,
   output logic [7:0] rsp_data_byte,
   output logic [3:0] rsp_msg_opcode,
   output logic       rsp_msg_last
);

   logic       item_valid;
   logic [7:0] item_byte;
   logic       out_free;
   logic       take;
   result_type result;

   // process a held byte whenever the result slot can take its outcome
   assign take = item_valid && out_free;

   wsd_in_stage u_in_stage (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_rx_byte (req_rx_byte),
      .take        (take),
      .item_valid  (item_valid),
      .item_byte   (item_byte)
   );

   wsd_parser u_parser (
      .clock   (clock),
      .reset   (reset),
      .fire    (take),
      .rx_byte (item_byte),
      .result  (result)
   );

   wsd_out_stage u_out_stage (
      .clock          (clock),
      .reset          (reset),
      .result         (result),
      .load           (take),
      .out_free       (out_free),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_out_kind   (rsp_out_kind),
      .rsp_data_byte  (rsp_data_byte),
      .rsp_msg_opcode (rsp_msg_opcode),
      .rsp_msg_last   (rsp_msg_last)
   );

endmodule

// ===== rtl/wsd_in_stage.sv =====
// ----------------------------------------------------------------------------
// wsd_in_stage
// Input register: captures one received byte and holds it until the parser
// takes it.
// ----------------------------------------------------------------------------
module wsd_in_stage import wsd_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_rx_byte,
   input  logic       take,
   output logic       item_valid,
   output logic [7:0] item_byte
);

   logic       valid_ff;
   logic       valid_in;
   logic [7:0] byte_ff;
   logic       accept;

   // stall only while a held word is not being taken
   assign req_stall = valid_ff && !take;
   assign accept    = req_valid && !req_stall;

   // load on accept, drop once taken
   always_comb begin
      if (accept) begin
         valid_in = 1'b1;
      end else if (take) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         byte_ff <= req_rx_byte;
      end
   end

   assign item_valid = valid_ff;
   assign item_byte  = byte_ff;

endmodule

// ===== rtl/wsd_parser.sv =====
// ----------------------------------------------------------------------------
// wsd_parser
// Frame header parser and payload counter. Consumes one byte per fire and
// produces at most one result word.
// ----------------------------------------------------------------------------
module wsd_parser import wsd_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       fire,
   input  logic [7:0] rx_byte,
   output result_type result
);

   logic [3:0]  header_bytes_seen_ff, header_bytes_seen_in;
   logic [7:0]  header_byte0_ff, header_byte0_in;
   logic [6:0]  short_length_ff, short_length_in;
   logic [63:0] payload_left_ff, payload_left_in;
   logic        in_payload_ff, in_payload_in;
   logic        message_active_ff, message_active_in;
   logic [3:0]  message_opcode_ff, message_opcode_in;
   logic        stopped_ff, stopped_in;

   logic        frame_fin;
   logic [3:0]  frame_op;
   logic        frame_ctl;
   logic        frame_close;
   logic        last_byte;
   logic        header_ok;
   logic [6:0]  len_code;
   logic [3:0]  hdr_need;
   logic [63:0] length_next;

   // decode the stored first header byte
   assign frame_fin   = header_byte0_ff[FIN_BIT];
   assign frame_op    = header_byte0_ff[3:0];
   assign frame_ctl   = frame_fin && frame_op[CTL_OP_BIT];
   assign frame_close = frame_ctl && (frame_op == OPCODE_CLOSE);
   assign last_byte   = (payload_left_ff == 64'd1);

   // header length needed for the current length code
   always_comb begin
      if (len_code == LEN_CODE_16) begin
         hdr_need = HDR_LEN_16;
      end else if (len_code == LEN_CODE_64) begin
         hdr_need = HDR_LEN_64;
      end else begin
         hdr_need = HDR_LEN_SHORT;
      end
   end

   // advance the frame state by one byte
   always_comb begin
      header_bytes_seen_in = header_bytes_seen_ff;
      header_byte0_in      = header_byte0_ff;
      short_length_in      = short_length_ff;
      payload_left_in      = payload_left_ff;
      in_payload_in        = in_payload_ff;
      message_active_in    = message_active_ff;
      message_opcode_in    = message_opcode_ff;
      stopped_in           = stopped_ff;
      header_ok            = 1'b0;
      len_code             = short_length_ff;
      length_next          = payload_left_ff;
      result               = '0;

      if (fire && !stopped_ff) begin
         if (in_payload_ff) begin
            // payload byte: stream data frames, count down
            payload_left_in = payload_left_ff - 64'd1;
            if (!frame_ctl) begin
               result.valid      = 1'b1;
               result.kind       = KIND_DATA;
               result.data_byte  = rx_byte;
               result.msg_opcode = message_opcode_ff;
               result.msg_last   = last_byte && frame_fin;
            end
            if (last_byte) begin
               in_payload_in        = 1'b0;
               header_bytes_seen_in = 4'd0;
               if (frame_close) begin
                  result.valid      = 1'b1;
                  result.kind       = KIND_CLOSE;
                  result.msg_opcode = OPCODE_CLOSE;
                  result.msg_last   = 1'b1;
               end else if (!frame_ctl && frame_fin) begin
                  message_active_in = 1'b0;
               end
            end
         end else if (header_bytes_seen_ff == 4'd0) begin
            header_byte0_in      = rx_byte;
            header_bytes_seen_in = 4'd1;
         end else if (header_bytes_seen_ff == 4'd1) begin
            if (rx_byte[MASK_BIT]) begin
               // masked frame: report once and halt
               stopped_in    = 1'b1;
               result.valid  = 1'b1;
               result.kind   = KIND_ERROR;
            end else begin
               header_ok            = 1'b1;
               len_code             = rx_byte[6:0];
               short_length_in      = rx_byte[6:0];
               length_next          = (rx_byte[6:0] < LEN_CODE_16) ?
                                      {57'd0, rx_byte[6:0]} : 64'd0;
               header_bytes_seen_in = 4'd2;
            end
         end else begin
            // extended length, big-endian
            header_ok            = 1'b1;
            length_next          = {payload_left_ff[55:0], rx_byte};
            header_bytes_seen_in = header_bytes_seen_ff + 4'd1;
         end

         if (header_ok) begin
            payload_left_in = length_next;
            if (header_bytes_seen_in >= hdr_need) begin
               // header complete
               if (!frame_ctl && !message_active_ff) begin
                  message_opcode_in = frame_op;
                  message_active_in = 1'b1;
               end
               if (length_next == 64'd0) begin
                  header_bytes_seen_in = 4'd0;
                  if (frame_close) begin
                     result.valid      = 1'b1;
                     result.kind       = KIND_CLOSE;
                     result.msg_opcode = OPCODE_CLOSE;
                     result.msg_last   = 1'b1;
                  end else if (!frame_ctl && frame_fin) begin
                     result.valid      = 1'b1;
                     result.kind       = KIND_END;
                     result.msg_opcode = message_opcode_in;
                     result.msg_last   = 1'b1;
                     message_active_in = 1'b0;
                  end
               end else begin
                  in_payload_in = 1'b1;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         header_bytes_seen_ff <= 4'd0;
         header_byte0_ff      <= 8'd0;
         short_length_ff      <= 7'd0;
         payload_left_ff      <= 64'd0;
         in_payload_ff        <= 1'b0;
         message_active_ff    <= 1'b0;
         message_opcode_ff    <= 4'd0;
         stopped_ff           <= 1'b0;
      end else begin
         header_bytes_seen_ff <= header_bytes_seen_in;
         header_byte0_ff      <= header_byte0_in;
         short_length_ff      <= short_length_in;
         payload_left_ff      <= payload_left_in;
         in_payload_ff        <= in_payload_in;
         message_active_ff    <= message_active_in;
         message_opcode_ff    <= message_opcode_in;
         stopped_ff           <= stopped_in;
      end
   end

   // an error result halts the parser on the next cycle
   a_error_halts: assert property (@(posedge clock) disable iff (reset)
      (result.valid && result.kind == KIND_ERROR) |=> stopped_ff)
      else $error("error result did not halt the parser");

   // a halted parser gives no results
   a_halt_silent: assert property (@(posedge clock) disable iff (reset)
      stopped_ff |-> !result.valid)
      else $error("result produced while halted");

   // payload phase always has bytes left
   a_payload_nonzero: assert property (@(posedge clock) disable iff (reset)
      in_payload_ff |-> (payload_left_ff != 64'd0))
      else $error("payload phase with zero length left");

   // header counter never runs past the longest header
   a_header_bound: assert property (@(posedge clock) disable iff (reset)
      header_bytes_seen_ff <= HDR_LEN_64)
      else $error("header byte count out of range");

endmodule

// ===== rtl/wsd_out_stage.sv =====
// ----------------------------------------------------------------------------
// wsd_out_stage
// Result register: holds one result word until the receiver takes it.
// ----------------------------------------------------------------------------
module wsd_out_stage import wsd_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  result_type result,
   input  logic       load,
   output logic       out_free,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [1:0] rsp_out_kind,
   output logic [7:0] rsp_data_byte,
   output logic [3:0] rsp_msg_opcode,
   output logic       rsp_msg_last
);

   logic       valid_ff;
   logic       valid_in;
   logic [1:0] kind_ff;
   logic [7:0] data_ff;
   logic [3:0] opcode_ff;
   logic       last_ff;
   logic       capture;

   // slot is free when empty or being drained this cycle
   assign out_free = !valid_ff || !rsp_stall;
   assign capture  = load && result.valid;

   // fill on a new result, drop once taken
   always_comb begin
      if (capture) begin
         valid_in = 1'b1;
      end else if (!rsp_stall) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (capture) begin
         kind_ff   <= result.kind;
         data_ff   <= result.data_byte;
         opcode_ff <= result.msg_opcode;
         last_ff   <= result.msg_last;
      end
   end

   assign rsp_valid      = valid_ff;
   assign rsp_out_kind   = kind_ff;
   assign rsp_data_byte  = data_ff;
   assign rsp_msg_opcode = opcode_ff;
   assign rsp_msg_last   = last_ff;

endmodule

// ===== bench/wsd_checker.sv =====
// ----------------------------------------------------------------------------
// wsd_checker
// Watches both channels of the frame deframer, predicts its result words and
// compares them.
// ----------------------------------------------------------------------------
// Each accepted received byte runs through a behavioral frame parser that
// keeps its own header, length and message state. Any result word it
// predicts is queued. Each accepted result word is matched, field by field,
// against the oldest queued word. Counts go back to the top for the verdict.
module wsd_checker import wsd_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [7:0]  req_rx_byte,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [1:0]  rsp_out_kind,
   input  logic [7:0]  rsp_data_byte,
   input  logic [3:0]  rsp_msg_opcode,
   input  logic        rsp_msg_last,
   output int unsigned mismatch_count,
   output int unsigned words_pending,
   output int unsigned words_checked,
   output int unsigned ends_seen,
   output int unsigned closes_seen
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      kind_type   kind;
      logic [7:0] data;
      logic [3:0] opcode;
      logic       last;
   } deframed_word_type;

   deframed_word_type expected_words[$];

   // parser state
   logic [3:0]  hdr_count;
   logic [7:0]  hdr_byte0;
   logic [6:0]  len_code;
   logic [63:0] bytes_left;
   logic        in_body;
   logic        msg_open;
   logic [3:0]  msg_op;
   logic        halted;

   int unsigned fails = 0;
   int unsigned checked = 0;
   int unsigned ends = 0;
   int unsigned closes = 0;

   function automatic deframed_word_type result_word(input kind_type kind,
                                                     input logic [7:0] data,
                                                     input logic [3:0] opcode,
                                                     input logic last);
      deframed_word_type w;
      w.kind   = kind;
      w.data   = data;
      w.opcode = opcode;
      w.last   = last;
      return w;
   endfunction

   // a control frame only counts as one when FIN is set
   function automatic logic is_control();
      return hdr_byte0[FIN_BIT] && hdr_byte0[CTL_OP_BIT];
   endfunction

   // close out the current frame after its header or its last payload byte
   task automatic close_frame(input logic had_payload);
      in_body   = 1'b0;
      hdr_count = 4'd0;
      if (is_control()) begin
         if (hdr_byte0[3:0] == OPCODE_CLOSE)
            expected_words.push_back(result_word(KIND_CLOSE, 8'h00, OPCODE_CLOSE, 1'b1));
      end else if (hdr_byte0[FIN_BIT]) begin
         if (!had_payload)
            expected_words.push_back(result_word(KIND_END, 8'h00, msg_op, 1'b1));
         msg_open = 1'b0;
      end
   endtask

   // advance the parser by one received byte
   task automatic deframe_byte(input logic [7:0] b);
      logic [3:0] hdr_need;
      if (halted)
         return;

      // payload: stream data bytes, drop control payload
      if (in_body) begin
         bytes_left = bytes_left - 64'd1;
         if (!is_control())
            expected_words.push_back(result_word(KIND_DATA, b, msg_op,
                                     bytes_left == 64'd0 && hdr_byte0[FIN_BIT]));
         if (bytes_left == 64'd0)
            close_frame(1'b1);
         return;
      end

      // header byte 0: FIN, reserved bits and opcode
      if (hdr_count == 4'd0) begin
         hdr_byte0 = b;
         hdr_count = 4'd1;
         return;
      end

      // header byte 1: mask and length code; later bytes extend the length
      if (hdr_count == 4'd1) begin
         if (b[MASK_BIT]) begin
            halted = 1'b1;
            expected_words.push_back(result_word(KIND_ERROR, 8'h00, 4'h0, 1'b0));
            return;
         end
         len_code   = b[6:0];
         bytes_left = (len_code < LEN_CODE_16) ? {57'd0, len_code} : 64'd0;
      end else begin
         bytes_left = {bytes_left[55:0], b};
      end
      hdr_count = hdr_count + 4'd1;

      hdr_need = (len_code == LEN_CODE_16) ? HDR_LEN_16 :
                 (len_code == LEN_CODE_64) ? HDR_LEN_64 : HDR_LEN_SHORT;
      if (hdr_count < hdr_need)
         return;

      // header done: the first data fragment fixes the message opcode
      if (!is_control() && !msg_open) begin
         msg_op   = hdr_byte0[3:0];
         msg_open = 1'b1;
      end
      if (bytes_left == 64'd0)
         close_frame(1'b0);
      else
         in_body = 1'b1;
   endtask

   task automatic check_field(input string field, input logic [7:0] want,
                              input logic [7:0] got);
      if (got !== want) begin
         $display("%0t ns: %s expected %0h actual %0h", $time, field, want, got);
         fails++;
      end
   endtask

   // predict on accepted bytes, compare on accepted words
   always @(posedge clock) begin : watch
      deframed_word_type want;
      if (reset) begin
         hdr_count  = 4'd0;
         hdr_byte0  = 8'h00;
         len_code   = 7'd0;
         bytes_left = 64'd0;
         in_body    = 1'b0;
         msg_open   = 1'b0;
         msg_op     = 4'h0;
         halted     = 1'b0;
         expected_words.delete();
      end else begin
         if (req_valid && !req_stall)
            deframe_byte(req_rx_byte);
         if (rsp_valid && !rsp_stall) begin
            if (expected_words.size() == 0) begin
               $display("%0t ns: unexpected word kind %0d data %0h opcode %0h last %0b",
                        $time, rsp_out_kind, rsp_data_byte, rsp_msg_opcode, rsp_msg_last);
               fails++;
            end else begin
               want = expected_words.pop_front();
               check_field("out_kind", 8'(want.kind), 8'(rsp_out_kind));
               check_field("data_byte", want.data, rsp_data_byte);
               check_field("msg_opcode", 8'(want.opcode), 8'(rsp_msg_opcode));
               check_field("msg_last", 8'(want.last), 8'(rsp_msg_last));
               checked++;
               if (want.kind == KIND_END)
                  ends++;
               if (want.kind == KIND_CLOSE)
                  closes++;
            end
         end
      end
      mismatch_count <= fails;
      words_pending  <= expected_words.size();
      words_checked  <= checked;
      ends_seen      <= ends;
      closes_seen    <= closes;
   end

endmodule

// ===== bench/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the WebSocket frame deframer.
// ----------------------------------------------------------------------------
// Drives a server byte stream: a short directed set of frames, then random
// fragmented messages with interleaved control frames across all three
// length forms, mixed with noise frames, and finally a masked frame that
// halts the block. Sender and receiver idle at random in the first two of
// three phases, and the receiver holds off once for a long stretch.
// Checking is done by wsd_checker beside the block.
module tb_top import wsd_pkg::*; ();
   timeunit 1ns;
   timeprecision 1ps;

   typedef enum {FORM_SHORT, FORM_16, FORM_64} len_form_type;

   localparam logic [3:0]  OP_CONT   = 4'h0;
   localparam logic [3:0]  OP_TEXT   = 4'h1;
   localparam logic [3:0]  OP_BINARY = 4'h2;
   localparam logic [3:0]  OP_PING   = 4'h9;
   localparam logic [3:0]  OP_PONG   = 4'hA;

   localparam int unsigned ITEM_TARGET  = 1750;
   localparam int unsigned PHASE_LEN    = 583;
   localparam int unsigned HOLD_AT      = 1300;
   localparam int unsigned HOLD_CYCLES  = 300;
   localparam int unsigned DRAIN_CYCLES = 20;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [7:0] req_rx_byte = 8'h00;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic [1:0] rsp_out_kind;
   logic [7:0] rsp_data_byte;
   logic [3:0] rsp_msg_opcode;
   logic       rsp_msg_last;

   int unsigned mismatch_count;
   int unsigned words_pending;
   int unsigned words_checked;
   int unsigned ends_seen;
   int unsigned closes_seen;

   int unsigned bytes_sent = 0;
   int unsigned send_idle_pct = 22;
   int unsigned recv_idle_pct = 60;
   int unsigned hold_left = 0;
   logic        hold_ask = 1'b0;
   logic        hold_done = 1'b0;

   websocket_frame_deframer dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_rx_byte    (req_rx_byte),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_out_kind   (rsp_out_kind),
      .rsp_data_byte  (rsp_data_byte),
      .rsp_msg_opcode (rsp_msg_opcode),
      .rsp_msg_last   (rsp_msg_last)
   );

   wsd_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_rx_byte    (req_rx_byte),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_out_kind   (rsp_out_kind),
      .rsp_data_byte  (rsp_data_byte),
      .rsp_msg_opcode (rsp_msg_opcode),
      .rsp_msg_last   (rsp_msg_last),
      .mismatch_count (mismatch_count),
      .words_pending  (words_pending),
      .words_checked  (words_checked),
      .ends_seen      (ends_seen),
      .closes_seen    (closes_seen)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   // receiver: random stalls, plus one long hold-off on request
   always @(posedge clock) begin
      if (hold_left != 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else if (hold_ask && !hold_done) begin
         rsp_stall <= 1'b1;
         hold_left <= HOLD_CYCLES;
         hold_done <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      end
   end

   // offer one byte and hold it until accepted
   task automatic send_byte(input logic [7:0] value);
      // pick idle rates for the current phase
      if (bytes_sent < PHASE_LEN) begin
         send_idle_pct = 22;
         recv_idle_pct = 60;
      end else if (bytes_sent < 2 * PHASE_LEN) begin
         send_idle_pct = 60;
         recv_idle_pct = 22;
      end else begin
         send_idle_pct = 0;
         recv_idle_pct = 0;
      end
      if (bytes_sent == HOLD_AT)
         hold_ask <= 1'b1;

      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
         while ($urandom_range(99) < send_idle_pct)
            @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_rx_byte <= value;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      bytes_sent++;
   endtask

   // frame header with mask clear; reserved bits random
   task automatic send_header(input logic fin, input logic [3:0] op,
                              input logic [63:0] len, input len_form_type form);
      send_byte({fin, 3'($urandom_range(7)), op});
      case (form)
         FORM_SHORT: begin
            send_byte({1'b0, len[6:0]});
         end
         FORM_16: begin
            send_byte({1'b0, LEN_CODE_16});
            send_byte(len[15:8]);
            send_byte(len[7:0]);
         end
         default: begin
            send_byte({1'b0, LEN_CODE_64});
            for (int i = 7; i >= 0; i--)
               send_byte(len[8*i +: 8]);
         end
      endcase
   endtask

   task automatic send_random_payload(input logic [63:0] count);
      for (longint unsigned k = 0; k < count; k++)
         send_byte(8'($urandom_range(255)));
   endtask

   // mostly short payloads, a few long ones, all three length forms
   task automatic pick_length(output logic [63:0] len, output len_form_type form);
      int unsigned r;
      r = $urandom_range(99);
      if (r < 60) begin
         form = FORM_SHORT;
         len  = 64'($urandom_range(20));
      end else if (r < 70) begin
         form = FORM_SHORT;
         len  = 64'($urandom_range(100, 125));
      end else if (r < 85) begin
         form = FORM_16;
         len  = ($urandom_range(9) == 0) ? 64'($urandom_range(700)) :
                                           64'($urandom_range(40));
      end else begin
         form = FORM_64;
         len  = 64'($urandom_range(40));
      end
   endtask

   // finished control frame: close, ping, pong or reserved control opcode
   task automatic send_control();
      logic [3:0] op;
      logic [63:0] len;
      case ($urandom_range(3))
         0: op = OPCODE_CLOSE;
         1: op = OP_PING;
         2: op = OP_PONG;
         default: op = 4'($urandom_range(11, 15));
      endcase
      len = 64'($urandom_range(8));
      send_header(1'b1, op, len, FORM_SHORT);
      send_random_payload(len);
   endtask

   // well-formed message of one to three fragments, control frames between
   task automatic send_message();
      logic [3:0]   first_op;
      logic [3:0]   op;
      logic [63:0]  len;
      len_form_type form;
      int unsigned  frags;
      frags = $urandom_range(1, 3);
      if ($urandom_range(9) == 0)
         first_op = 4'($urandom_range(3, 7));
      else
         first_op = $urandom_range(1) ? OP_TEXT : OP_BINARY;
      for (int f = 0; f < frags; f++) begin
         if (f == 0)
            op = first_op;
         else
            op = ($urandom_range(9) == 0) ? 4'($urandom_range(15)) : OP_CONT;
         pick_length(len, form);
         send_header(f == frags - 1, op, len, form);
         send_random_payload(len);
         if ($urandom_range(3) == 0)
            send_control();
      end
   endtask

   // noise: any FIN and opcode, short payload
   task automatic send_noise();
      logic [63:0] len;
      len = 64'($urandom_range(30));
      send_header(1'($urandom_range(1)), 4'($urandom_range(15)), len, FORM_SHORT);
      send_random_payload(len);
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // empty final frame: end marker tagged with its own opcode
      send_header(1'b1, OP_BINARY, 64'd0, FORM_SHORT);
      // fragmented text message with a ping inside, an empty non-final
      // continuation, a non-final control opcode carried as data, and a
      // final continuation in the 16-bit form with the byte extremes
      send_header(1'b0, OP_TEXT, 64'd1, FORM_SHORT);
      send_random_payload(64'd1);
      send_header(1'b1, OP_PING, 64'd0, FORM_SHORT);
      send_header(1'b0, OP_CONT, 64'd0, FORM_SHORT);
      send_header(1'b0, OP_PONG, 64'd1, FORM_SHORT);
      send_random_payload(64'd1);
      send_header(1'b1, OP_CONT, 64'd2, FORM_16);
      send_byte(8'h00);
      send_byte(8'hFF);
      // close with payload: event comes with its last byte
      send_header(1'b1, OPCODE_CLOSE, 64'd1, FORM_SHORT);
      send_random_payload(64'd1);

      // random messages with some noise frames
      while (bytes_sent < ITEM_TARGET) begin
         if ($urandom_range(99) < 85)
            send_message();
         else
            send_noise();
      end

      // masked frame halts the block; the bytes after it are swallowed
      send_byte({1'b1, 3'b000, OP_TEXT});
      send_byte({1'b1, 7'($urandom_range(127))});
      repeat (8)
         send_byte(8'($urandom_range(255)));
      req_valid <= 1'b0;

      // drain, then give the verdict
      @(posedge clock);
      while (words_pending != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("Covered %0d received bytes: fragmented messages, control frames, all length",
               bytes_sent);
      $display("forms, a long receiver hold-off and a masked-frame halt; %0d words checked",
               words_checked);
      $display("(%0d ends, %0d closes).", ends_seen, closes_seen);
      if (mismatch_count == 0 && words_pending == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // stop a hung run
   initial begin
      #800000;
      $display("Timeout with %0d words still expected", words_pending);
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
